>>> rtl/core/two_level_page_table_engine_top_defines.svh
// Assertion macros shared by the page table engine modules.
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLPT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tlpt_pkg.sv
// Types and constants shared by the page table engine modules.
package tlpt_pkg;

	localparam int DIR_AW      = 10;
	localparam int TBL_AW      = 10;
	localparam int OFF_W       = 12;
	localparam int FRAME_W     = 20;
	localparam int ENTRY_W     = 26;
	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);

	localparam int E_USER    = 3;
	localparam int E_PRESENT = 5;

	// Unmap keeps global, uncachable, writethrough, user and writable.
	localparam logic [ENTRY_W-1:0] KEEP_MASK = ENTRY_W'(6'h1F);

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_UNMAP = 2'd1,
		OP_XLATE = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POOL_FULL = 2'd1,
		ST_NO_TABLE  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                op;
		status_t            status;
		logic               has_table;
		logic [ENTRY_W-1:0] entry;
		logic [OFF_W-1:0]   offset;
		logic               user_check;
	} cmd_t;

endpackage

>>> rtl/core/tlpt_front.sv
// Front end: accepts requests, reads the directory and allocates tables.
`include "two_level_page_table_engine_top_defines.svh"

module tlpt_front #(
	parameter int POOL_TABLES = 16,
	localparam int SW = $clog2(POOL_TABLES) + tlpt_pkg::TBL_AW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [1:0]          opcode,
	input  logic [31:0]         virt_addr,
	input  logic [31:0]         phys_addr,
	input  logic [5:0]          page_flags,
	input  logic                user_check,
	output logic                front_busy,
	output logic                push,
	output tlpt_pkg::cmd_t      push_cmd,
	output logic [SW-1:0]       push_slot
);

	localparam int DW = $clog2(POOL_TABLES + 1);

	logic [DW-1:0] dir_mem [2**tlpt_pkg::DIR_AW];
	logic [DW-1:0] dir_rd_q;
	logic [tlpt_pkg::DIR_AW-1:0] sw_cnt_q;
	logic sweep_q;
	logic v_s1;
	logic [DW-1:0] used_q;

	tlpt_pkg::op_t op_s1;
	logic [31:0] va_s1;
	logic [tlpt_pkg::FRAME_W-1:0] frame_s1;
	logic [5:0] fl_s1;
	logic usr_s1;

	logic has_tbl;
	logic room;
	logic alloc;
	logic [DW-1:0] tbl;

	assign has_tbl = dir_rd_q != '0;
	assign room = used_q < DW'(POOL_TABLES);
	assign alloc = v_s1 && (op_s1 == tlpt_pkg::OP_MAP) && !has_tbl && room;
	assign tbl = has_tbl ? dir_rd_q - DW'(1) : used_q;

	assign front_busy = sweep_q | v_s1;
	assign push = v_s1;
	assign push_slot = (SW'(tbl) << tlpt_pkg::TBL_AW) | SW'(va_s1[21:12]);

	always_comb begin
		push_cmd.op = op_s1;
		push_cmd.status = tlpt_pkg::ST_OK;
		if ((op_s1 == tlpt_pkg::OP_MAP) && !has_tbl && !room) begin
			push_cmd.status = tlpt_pkg::ST_POOL_FULL;
		end
		if ((op_s1 == tlpt_pkg::OP_UNMAP) && !has_tbl) begin
			push_cmd.status = tlpt_pkg::ST_NO_TABLE;
		end
		push_cmd.has_table = has_tbl || ((op_s1 == tlpt_pkg::OP_MAP) && room);
		push_cmd.entry = {frame_s1, ~fl_s1[5], ~fl_s1[4], fl_s1[3:0]};
		push_cmd.offset = va_s1[tlpt_pkg::OFF_W-1:0];
		push_cmd.user_check = usr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b1;
			sw_cnt_q <= '0;
			v_s1 <= 1'b0;
			used_q <= '0;
		end else begin
			if (sweep_q) begin
				sw_cnt_q <= sw_cnt_q + 1'b1;
				if (&sw_cnt_q) begin
					sweep_q <= 1'b0;
				end
			end
			v_s1 <= take;
			if (alloc) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= tlpt_pkg::op_t'(opcode);
			va_s1 <= virt_addr;
			frame_s1 <= phys_addr[31:12];
			fl_s1 <= page_flags;
			usr_s1 <= user_check;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			dir_mem[sw_cnt_q] <= '0;
		end else if (alloc) begin
			dir_mem[va_s1[31:22]] <= used_q + 1'b1;
		end
		if (take) begin
			dir_rd_q <= dir_mem[virt_addr[31:22]];
		end
	end

	`TLPT_ASSERT_NEXT(a_front_one_cycle, v_s1, !v_s1, "Front stage held a request twice.")
	`TLPT_ASSERT_SAME(a_front_no_sweep, sweep_q, !v_s1, "Request taken during directory clear.")

endmodule

>>> rtl/core/tlpt_queue.sv
// Short queue of classified requests between the front and back ends.
module tlpt_queue #(
	parameter int SW = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tlpt_pkg::cmd_t push_cmd,
	input  logic [SW-1:0]  push_slot,
	input  logic           pop,
	output logic           full,
	output logic           filled,
	output tlpt_pkg::cmd_t head_cmd,
	output logic [SW-1:0]  head_slot
);

	tlpt_pkg::cmd_t cmd_q [tlpt_pkg::QUEUE_DEPTH];
	logic [SW-1:0] slot_q [tlpt_pkg::QUEUE_DEPTH];
	logic [tlpt_pkg::QP_W-1:0] wr_ptr_q;
	logic [tlpt_pkg::QP_W-1:0] rd_ptr_q;
	logic [tlpt_pkg::QP_W:0] cnt_q;

	assign full = cnt_q == (tlpt_pkg::QP_W + 1)'(tlpt_pkg::QUEUE_DEPTH);
	assign filled = cnt_q != '0;
	assign head_cmd = cmd_q[rd_ptr_q];
	assign head_slot = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= push_cmd;
			slot_q[wr_ptr_q] <= push_slot;
		end
	end

endmodule

>>> rtl/core/tlpt_back.sv
// Back end: reads and updates page entries and produces results.
`include "two_level_page_table_engine_top_defines.svh"

module tlpt_back #(
	parameter int POOL_TABLES = 16,
	localparam int SW = $clog2(POOL_TABLES) + tlpt_pkg::TBL_AW
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_filled,
	input  tlpt_pkg::cmd_t head_cmd,
	input  logic [SW-1:0]  head_slot,
	output logic           pop,
	output logic           back_busy,
	output logic           done,
	output logic [1:0]     status,
	output logic [31:0]    phys_out,
	output logic           valid_out
);

	localparam int PG_DEPTH = POOL_TABLES * (2**tlpt_pkg::TBL_AW);

	logic [tlpt_pkg::ENTRY_W-1:0] pg_mem [PG_DEPTH];
	logic [tlpt_pkg::ENTRY_W-1:0] pg_rd_q;
	logic [SW-1:0] sw_cnt_q;
	logic sweep_q;
	logic v_b1;
	logic done_q;

	tlpt_pkg::cmd_t cmd_b1;
	logic [SW-1:0] slot_b1;
	logic [1:0] status_q;
	logic [31:0] phys_q;
	logic valid_q;

	logic present;
	logic [31:0] phys_d;
	logic valid_d;

	assign pop = q_filled && !v_b1 && !sweep_q;
	assign back_busy = sweep_q;
	assign present = pg_rd_q[tlpt_pkg::E_PRESENT];

	assign done = done_q;
	assign status = status_q;
	assign phys_out = phys_q;
	assign valid_out = valid_q;

	always_comb begin
		phys_d = '0;
		valid_d = 1'b0;
		unique case (cmd_b1.op)
			tlpt_pkg::OP_XLATE: begin
				if (cmd_b1.has_table && present) begin
					phys_d = {pg_rd_q[tlpt_pkg::ENTRY_W-1:6], cmd_b1.offset};
					valid_d = 1'b1;
				end
			end
			tlpt_pkg::OP_CHECK: begin
				valid_d = cmd_b1.has_table && present
					&& (!cmd_b1.user_check || pg_rd_q[tlpt_pkg::E_USER]);
			end
			tlpt_pkg::OP_MAP, tlpt_pkg::OP_UNMAP: begin
				valid_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b1;
			sw_cnt_q <= '0;
			v_b1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (sweep_q) begin
				sw_cnt_q <= sw_cnt_q + 1'b1;
				if (sw_cnt_q == SW'(PG_DEPTH - 1)) begin
					sweep_q <= 1'b0;
				end
			end
			v_b1 <= pop;
			done_q <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_b1 <= head_cmd;
			slot_b1 <= head_slot;
		end
		if (v_b1) begin
			status_q <= cmd_b1.status;
			phys_q <= phys_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			pg_mem[sw_cnt_q] <= '0;
		end else if (v_b1 && cmd_b1.has_table) begin
			if (cmd_b1.op == tlpt_pkg::OP_MAP) begin
				pg_mem[slot_b1] <= cmd_b1.entry;
			end else if (cmd_b1.op == tlpt_pkg::OP_UNMAP) begin
				pg_mem[slot_b1] <= pg_rd_q & tlpt_pkg::KEEP_MASK;
			end
		end
		if (pop) begin
			pg_rd_q <= pg_mem[head_slot];
		end
	end

	`TLPT_ASSERT_NEXT(a_back_one_cycle, v_b1, !v_b1, "Back stage held a request twice.")
	`TLPT_ASSERT_NEXT(a_back_result, v_b1, done_q, "Back stage request gave no result.")
	`TLPT_ASSERT_SAME(a_back_quiet_sweep, sweep_q, !done_q, "Result strobed during page clear.")

endmodule

>>> rtl/core/two_level_page_table_engine_top.sv
// Top level of the two-level page table engine.
//
//  Channel   Handshake          Payload
//  request   start / busy       opcode, virt_addr, phys_addr, page_flags, user_check
//  result    done (one cycle)   status, phys_out, valid_out
//
// A new request is not taken while the front stage holds the previous one: the front end
// reads the directory as it takes a request, then classifies it and allocates a table.
// The back end reads the page entry as it pops a request, then writes the entry or forms
// the result; done follows the front stage, the queue and the back stage registers.
// After reset the directory and page store are cleared, with busy held high.
// Busy is also high while the front stage holds a request or the queue is full; results
// cannot be held off.
module two_level_page_table_engine_top #(
	parameter int POOL_TABLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] virt_addr,
	input  logic [31:0] phys_addr,
	input  logic [5:0]  page_flags,
	input  logic        user_check,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] phys_out,
	output logic        valid_out
);

	localparam int SW = $clog2(POOL_TABLES) + tlpt_pkg::TBL_AW;

	logic take;
	logic front_busy;
	logic back_busy;
	logic push;
	tlpt_pkg::cmd_t push_cmd;
	logic [SW-1:0] push_slot;
	logic pop;
	logic q_full;
	logic q_filled;
	tlpt_pkg::cmd_t head_cmd;
	logic [SW-1:0] head_slot;

	assign busy = front_busy | back_busy | q_full;
	assign take = start && !busy;

	tlpt_front #(.POOL_TABLES(POOL_TABLES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.opcode     (opcode),
		.virt_addr  (virt_addr),
		.phys_addr  (phys_addr),
		.page_flags (page_flags),
		.user_check (user_check),
		.front_busy (front_busy),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_slot  (push_slot)
	);

	tlpt_queue #(.SW(SW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_slot (push_slot),
		.pop       (pop),
		.full      (q_full),
		.filled    (q_filled),
		.head_cmd  (head_cmd),
		.head_slot (head_slot)
	);

	tlpt_back #(.POOL_TABLES(POOL_TABLES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_filled  (q_filled),
		.head_cmd  (head_cmd),
		.head_slot (head_slot),
		.pop       (pop),
		.back_busy (back_busy),
		.done      (done),
		.status    (status),
		.phys_out  (phys_out),
		.valid_out (valid_out)
	);

endmodule

>>> dv/page_table_checker.sv
// Checker that follows the request and result channels of the page table engine and compares results.
module page_table_checker
	import tlpt_pkg::*;
#(
	parameter int POOL_TABLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] virt_addr,
	input  logic [31:0] phys_addr,
	input  logic [5:0]  page_flags,
	input  logic        user_check,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [31:0] phys_out,
	input  logic        valid_out,
	output int          errors,
	output int          outstanding
);

	localparam int TAG_W = $clog2(POOL_TABLES + 1);

	typedef struct {
		status_t     status;
		logic [31:0] phys;
		logic        valid;
	} outcome_t;

	logic [TAG_W-1:0]   region_dir   [1 << DIR_AW];
	logic [ENTRY_W-1:0] page_entries [POOL_TABLES << TBL_AW];
	int                 tables_used;
	outcome_t           awaited_results [$];

	function automatic outcome_t resolve_request(op_t op, logic [31:0] va, logic [31:0] pa,
			logic [5:0] fl, logic uc);
		outcome_t           r;
		logic [DIR_AW-1:0]  dir;
		logic [TBL_AW-1:0]  pg;
		logic [ENTRY_W-1:0] e;
		int                 slot;
		r.status = ST_OK;
		r.phys   = '0;
		r.valid  = 1'b0;
		dir      = va[31:22];
		pg       = va[21:12];
		slot     = -1;
		if (region_dir[dir] != '0)
			slot = (int'(region_dir[dir]) - 1) * (1 << TBL_AW) + int'(pg);
		case (op)
			OP_MAP: begin
				if (slot < 0) begin
					if (tables_used < POOL_TABLES) begin
						for (int i = 0; i < (1 << TBL_AW); i++)
							page_entries[tables_used * (1 << TBL_AW) + i] = '0;
						region_dir[dir] = TAG_W'(tables_used + 1);
						slot = tables_used * (1 << TBL_AW) + int'(pg);
						tables_used++;
					end else begin
						r.status = ST_POOL_FULL;
					end
				end
				if (slot >= 0) begin
					e = {pa[31:12], ~fl[5], ~fl[4], fl[3:0]};
					page_entries[slot] = e;
				end
			end
			OP_UNMAP: begin
				if (slot < 0)
					r.status = ST_NO_TABLE;
				else
					page_entries[slot] = page_entries[slot] & KEEP_MASK;
			end
			OP_XLATE: begin
				if (slot >= 0) begin
					e = page_entries[slot];
					if (e[E_PRESENT]) begin
						r.phys  = {e[ENTRY_W-1:6], va[OFF_W-1:0]};
						r.valid = 1'b1;
					end
				end
			end
			OP_CHECK: begin
				if (slot >= 0) begin
					e = page_entries[slot];
					r.valid = e[E_PRESENT] && (!uc || e[E_USER]);
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			foreach (region_dir[i])
				region_dir[i] = '0;
			foreach (page_entries[i])
				page_entries[i] = '0;
			tables_used = 0;
			awaited_results.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result arrived with no request outstanding");
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						errors++;
					end
					if (phys_out !== want.phys) begin
						$error("phys_out: expected %h, actual %h", want.phys, phys_out);
						errors++;
					end
					if (valid_out !== want.valid) begin
						$error("valid_out: expected %0b, actual %0b", want.valid, valid_out);
						errors++;
					end
				end
			end
			if (start && !busy)
				awaited_results.push_back(resolve_request(op_t'(opcode), virt_addr, phys_addr,
					page_flags, user_check));
			outstanding = awaited_results.size();
		end
	end

endmodule

>>> dv/tb.sv
// Testbench top for the page table engine: clock, reset, request stimulus and the verdict.
module tb;
	import tlpt_pkg::*;

	localparam int POOL_TABLES = 16;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [31:0] virt_addr;
	logic [31:0] phys_addr;
	logic [5:0]  page_flags;
	logic        user_check;
	logic        done;
	logic [1:0]  status;
	logic [31:0] phys_out;
	logic        valid_out;
	int          errors;
	int          outstanding;
	int          idle_pct;
	logic [DIR_AW-1:0] hot_regions [20];

	two_level_page_table_engine_top #(.POOL_TABLES(POOL_TABLES)) DUT (.*);

	page_table_checker #(.POOL_TABLES(POOL_TABLES)) u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	task automatic send_request(input op_t op, input logic [31:0] va, input logic [31:0] pa,
			input logic [5:0] fl, input logic uc);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start      <= 1'b1;
		opcode     <= op;
		virt_addr  <= va;
		phys_addr  <= pa;
		page_flags <= fl;
		user_check <= uc;
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic random_request(input bit noisy);
		logic [31:0] va;
		op_t         op;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 30)
			op = OP_MAP;
		else if (pick < 45)
			op = OP_UNMAP;
		else if (pick < 75)
			op = OP_XLATE;
		else
			op = OP_CHECK;
		if (noisy) begin
			va = $urandom();
			op = op_t'($urandom_range(3));
		end else begin
			va[31:22] = hot_regions[$urandom_range(19)];
			va[21:12] = ($urandom_range(99) < 70) ? 10'($urandom_range(7)) : 10'($urandom());
			va[11:0]  = 12'($urandom());
		end
		send_request(op, va, $urandom(), 6'($urandom()), 1'($urandom()));
	endtask

	initial begin
		start      = 1'b0;
		opcode     = OP_MAP;
		virt_addr  = '0;
		phys_addr  = '0;
		page_flags = '0;
		user_check = 1'b0;
		arst_n     = 1'b0;
		idle_pct   = 14;
		hot_regions[0] = 10'd0;
		hot_regions[1] = 10'd1023;
		hot_regions[2] = 10'd511;
		for (int i = 3; i < 20; i++)
			hot_regions[i] = 10'($urandom());
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Lookups and unmap before any table exists, then first use of a few regions.
		send_request(OP_XLATE, 32'h0000_0000, 32'h0, 6'h00, 1'b0);
		send_request(OP_CHECK, 32'h0000_0000, 32'h0, 6'h00, 1'b1);
		send_request(OP_UNMAP, 32'h0000_0000, 32'h0, 6'h00, 1'b0);
		send_request(OP_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 6'h00, 1'b0);
		send_request(OP_XLATE, 32'h0000_0FFF, 32'h0, 6'h00, 1'b0);
		send_request(OP_CHECK, 32'h0000_0FFF, 32'h0, 6'h00, 1'b1);
		send_request(OP_CHECK, 32'h0000_0FFF, 32'h0, 6'h00, 1'b0);
		send_request(OP_XLATE, 32'h0000_1000, 32'h0, 6'h00, 1'b0);
		send_request(OP_MAP,   32'hFFFF_FFFF, 32'h0, 6'h3F, 1'b1);
		send_request(OP_XLATE, 32'hFFFF_FFFF, 32'h0, 6'h00, 1'b0);
		send_request(OP_CHECK, 32'hFFFF_FFFF, 32'h0, 6'h00, 1'b0);
		// Overwrite of an existing entry, then unmap keeps the remaining flag bits.
		send_request(OP_MAP,   32'hFFFF_F123, 32'h1234_5678, 6'h08, 1'b0);
		send_request(OP_CHECK, 32'hFFFF_F000, 32'h0, 6'h00, 1'b1);
		send_request(OP_XLATE, 32'hFFFF_F123, 32'h0, 6'h00, 1'b0);
		send_request(OP_UNMAP, 32'hFFFF_F000, 32'h0, 6'h00, 1'b0);
		send_request(OP_XLATE, 32'hFFFF_F123, 32'h0, 6'h00, 1'b0);
		send_request(OP_CHECK, 32'hFFFF_F123, 32'h0, 6'h00, 1'b0);
		send_request(OP_MAP,   32'hFFFF_F000, 32'hABCD_E000, 6'h37, 1'b0);
		send_request(OP_CHECK, 32'hFFFF_F000, 32'h0, 6'h00, 1'b0);
		send_request(OP_UNMAP, 32'h7FC0_0000, 32'h0, 6'h00, 1'b0);
		send_request(OP_MAP,   32'h7FC0_0000, 32'h0000_0FFF, 6'h10, 1'b0);
		send_request(OP_XLATE, 32'h7FFF_FFFF, 32'h0, 6'h00, 1'b0);
		send_request(OP_XLATE, 32'h7FC0_0ABC, 32'h0, 6'h00, 1'b0);
		wait_for_results();

		for (int n = 0; n < 1400; n++) begin
			idle_pct = (n >= 500 && n < 900) ? 0 : 14;
			if (n == 700)
				wait_for_results();
			random_request(n >= 300 && $urandom_range(99) < 15);
		end
		wait_for_results();
		repeat (8) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
